// File: design/kmsg_pkg.sv
`timescale 1ns / 1ps

package kmsg_pkg;

   // Field widths fixed by the channel format
   localparam int ROW_IDX_W   = 3;
   localparam int COL_MAX_W   = 16;
   localparam int KEY_CNT_W   = 8;

   // Defaults for the top level parameters
   localparam int DEF_ROWS    = 8;
   localparam int DEF_COLS    = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_index;
      logic [COL_MAX_W-1:0] raw_columns;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic                 modified;
      logic                 ghost;
      logic [KEY_CNT_W-1:0] key_count;
   } rsp_type;

   // Classified row command: key bits already inverted and masked to the column count
   typedef struct packed {
      logic                 write_en;
      logic [ROW_IDX_W-1:0] row_index;
      logic [COL_MAX_W-1:0] keys;
      logic                 frame_end;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } back_state_type;

endpackage

// File: design/kmsg_front.sv
`timescale 1ns / 1ps

module kmsg_front #(
   parameter int ROWS = kmsg_pkg::DEF_ROWS,
   parameter int COLS = kmsg_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmsg_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output kmsg_pkg::cmd_type cmd_data
);
   import kmsg_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COL_MAX_W-1:0] ColMask = COL_MAX_W'((33'd1 << COLS) - 33'd1);

   cmd_type    cmd_new;
   cmd_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   // Classify: rows past the matrix are not stored, but a frame end still counts
   always_comb begin
      cmd_new.write_en  = (32'(req_data.row_index) < ROWS);
      cmd_new.row_index = req_data.row_index;
      cmd_new.keys      = (~req_data.raw_columns) & ColMask;
      cmd_new.frame_end = req_data.frame_end;
   end

   assign req_stall = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = slot_ff[rd_ptr_ff];

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: design/kmsg_back.sv
`timescale 1ns / 1ps

module kmsg_back #(
   parameter int ROWS = kmsg_pkg::DEF_ROWS,
   parameter int COLS = kmsg_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  kmsg_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmsg_pkg::rsp_type rsp_data
);
   import kmsg_pkg::*;

   localparam int RW    = $clog2(ROWS);
   localparam int SUM_W = $clog2(ROWS * COLS + 1);
   localparam int POP_W = $clog2(COLS + 1);

   back_state_type state_ff, state_in;

   logic [COLS-1:0]  cur_ff  [ROWS];
   logic [COLS-1:0]  prev_ff [ROWS];
   logic [RW-1:0]    row_ff, row_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             mod_ff, mod_in;
   logic             ghost_ff, ghost_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             start_walk;
   logic             walking;
   logic             load_rsp;
   logic             store_row;
   logic             last_row;
   logic             rsp_free;
   logic [COLS-1:0]  walk_row;
   logic [POP_W-1:0] walk_pop;
   logic             walk_multi;
   logic             walk_match;
   logic [31:0]      sum_wide;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign last_row = (row_ff == RW'(ROWS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_data.frame_end) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_row) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_take   = 1'b0;
      walking    = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:   cmd_take = 1'b1;
         ST_WALK:   walking  = 1'b1;
         ST_RESULT: load_rsp = rsp_free;
         default:   cmd_take = 1'b0;
      endcase
   end

   assign store_row  = cmd_take && cmd_valid && cmd_data.write_en;
   assign start_walk = cmd_take && cmd_valid && cmd_data.frame_end;

   // One row per walk step: popcount, multi-key test, compare against later rows
   always_comb begin
      walk_row   = cur_ff[row_ff];
      walk_pop   = '0;
      walk_match = 1'b0;
      for (int c = 0; c < COLS; c++) begin
         walk_pop = walk_pop + POP_W'(walk_row[c]);
      end
      walk_multi = ((walk_row & (walk_row - 1'b1)) != '0);
      for (int s = 0; s < ROWS; s++) begin
         if ((s > int'(row_ff)) && (cur_ff[s] == walk_row)) begin
            walk_match = 1'b1;
         end
      end
   end

   // Walk accumulators
   always_comb begin
      row_in   = row_ff;
      sum_in   = sum_ff;
      mod_in   = mod_ff;
      ghost_in = ghost_ff;
      if (start_walk) begin
         row_in   = '0;
         sum_in   = '0;
         mod_in   = 1'b0;
         ghost_in = 1'b0;
      end else if (walking) begin
         row_in   = last_row ? '0 : row_ff + 1'b1;
         sum_in   = sum_ff + SUM_W'(walk_pop);
         mod_in   = mod_ff || (walk_row != prev_ff[row_ff]);
         ghost_in = ghost_ff || (walk_multi && walk_match);
      end
   end

   // Result register, count saturates at the field's top value
   always_comb begin
      sum_wide     = 32'(sum_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (load_rsp) begin
         rsp_valid_in     = 1'b1;
         rsp_in.modified  = mod_ff;
         rsp_in.ghost     = ghost_ff;
         rsp_in.key_count = (sum_wide > 32'd255) ? '1 : sum_wide[KEY_CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      mod_ff   <= mod_in;
      ghost_ff <= ghost_in;
      rsp_ff   <= rsp_in;
   end

   // Frame store: row writes while idle, current copied into previous during the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            cur_ff[r]  <= '0;
            prev_ff[r] <= '0;
         end
      end else begin
         if (store_row) begin
            cur_ff[RW'(cmd_data.row_index)] <= cmd_data.keys[COLS-1:0];
         end
         if (walking) begin
            prev_ff[row_ff] <= walk_row;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/key_matrix_scan_ghost_detect_unit.sv
`timescale 1ns / 1ps

// Keyboard matrix scanner with ghost detection. Each request transfer carries one row's
// active-low column reading; the inverted reading becomes that row's key state. A transfer
// with frame_end set yields one response: modified (any row changed since the last frame
// end), ghost (a row with two or more keys equals a later row) and key_count (pressed keys,
// saturating at 255). Rows at or past ROWS are not stored but their frame_end still counts.
// The back end takes a row without frame_end while idle; a frame end starts a walk
// (store, one walk step per row over the frame store, result load). A two-entry command
// queue in front holds up to two request transfers during that walk, and a response
// register lets the next frame proceed while a result waits.
module key_matrix_scan_ghost_detect_unit #(
   parameter int ROWS = kmsg_pkg::DEF_ROWS,
   parameter int COLS = kmsg_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmsg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmsg_pkg::rsp_type rsp_data
);
   import kmsg_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   kmsg_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   kmsg_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
